// ----- rtl/gregorian_date_add_days_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Gregorian date adder
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ADD_DAYS_TOP_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define GDA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gda assertion failed");

// Next-cycle implication
`define GDA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gda assertion failed");

`else

`define GDA_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define GDA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/gda_pkg.sv -----
// ----------------------------------------------------------------------------
// Gregorian date adder package
// Field types, calendar constants, sequencer states and month length lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package gda_pkg;

  localparam int YEAR_W          = 14;
  localparam int MONTH_W         = 4;
  localparam int DAY_W           = 5;
  localparam int OFFSET_BITS_DEF = 21;

  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;

  localparam year_t  MIN_VALID_YEAR = year_t'(1900);
  localparam year_t  MIN_YEAR       = year_t'(1);
  localparam year_t  MAX_YEAR       = year_t'(9999);
  localparam year_t  ERA_YEARS      = year_t'(400);
  localparam year_t  CENTURY_YEARS  = year_t'(100);

  localparam month_t JANUARY  = month_t'(1);
  localparam month_t FEBRUARY = month_t'(2);
  localparam month_t DECEMBER = month_t'(12);

  localparam day_t   FIRST_DAY    = day_t'(1);
  localparam day_t   DECEMBER_LEN = day_t'(31);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_WALK,
    ST_DONE
  } state_t;

  // Leap test from the year taken modulo 400
  function automatic logic is_leap(input year_t yr400);
    logic cent;
    cent = (yr400 == CENTURY_YEARS) || (yr400 == year_t'(2 * 100)) ||
           (yr400 == year_t'(3 * 100));
    return (yr400[1:0] == 2'b00) && !cent;
  endfunction

  // Days in a month; codes outside 1..12 give zero
  function automatic day_t month_len(input month_t mon, input logic leap);
    day_t len;
    unique case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = day_t'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                     len = day_t'(30);
      4'd2:                                        len = leap ? day_t'(29) : day_t'(28);
      default:                                     len = day_t'(0);
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gda_in_if.sv -----
// ----------------------------------------------------------------------------
// Date adder request channel
// Start date and signed day offset with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface gda_in_if #(
  parameter int OFFSET_BITS = gda_pkg::OFFSET_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  gda_pkg::year_t                start_year;
  gda_pkg::month_t               start_month;
  gda_pkg::day_t                 start_day;
  logic signed [OFFSET_BITS-1:0] day_offset;

  modport source (
    output valid, start_year, start_month, start_day, day_offset,
    input  ready
  );

  modport sink (
    input  valid, start_year, start_month, start_day, day_offset,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/gda_out_if.sv -----
// ----------------------------------------------------------------------------
// Date adder result channel
// Result date and status flags with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface gda_out_if;
  logic            valid;
  logic            ready;
  gda_pkg::year_t  result_year;
  gda_pkg::month_t result_month;
  gda_pkg::day_t   result_day;
  logic            input_invalid;
  logic            year_overflow;

  modport source (
    output valid, result_year, result_month, result_day, input_invalid, year_overflow,
    input  ready
  );

  modport sink (
    input  valid, result_year, result_month, result_day, input_invalid, year_overflow,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/gregorian_date_add_days_top.sv -----
// ----------------------------------------------------------------------------
// Gregorian date adder
// Adds a signed day count to a date by walking one month per cycle.
// ----------------------------------------------------------------------------
//
//   channel  dir   payload
//   req      in    start_year, start_month, start_day, day_offset
//   rsp      out   result_year, result_month, result_day, input_invalid,
//                  year_overflow
//
// One word is in flight at a time; req.ready is high only while idle.
// Each word is reduced by whole eras, checked, then walked month by month
// on the shared subtractor, which crosses one month boundary per cycle;
// a rejected start date skips the walk.
// rst is synchronous and clears the sequencer only.
// A stalled result holds in the output registers until rsp.ready.
//
`default_nettype none

`include "gregorian_date_add_days_top_assert.svh"

module gregorian_date_add_days_top #(
  parameter int OFFSET_BITS = gda_pkg::OFFSET_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  gda_in_if.sink    req,
  gda_out_if.source rsp
);

  localparam int MagW = (OFFSET_BITS > gda_pkg::YEAR_W) ? OFFSET_BITS : gda_pkg::YEAR_W;
  localparam int SubW = MagW + 1;

  gda_pkg::state_t state, state_next;

  gda_pkg::year_t  year, year_next;
  gda_pkg::month_t month, month_next;
  gda_pkg::day_t   day, day_next;
  gda_pkg::year_t  yrem, yrem_next;
  logic [MagW-1:0] mag, mag_next;
  logic            back, back_next;
  logic            bad, bad_next;
  logic            ovf, ovf_next;
  gda_pkg::year_t  sy, sy_next;
  gda_pkg::month_t sm, sm_next;
  gda_pkg::day_t   sd, sd_next;

  logic                   leap;
  gda_pkg::month_t        len_month;
  gda_pkg::day_t          len;
  gda_pkg::day_t          left_p1;
  logic [SubW-1:0]        opa, opb, diff;
  logic                   sub_neg;
  logic                   start_bad;
  logic                   edge_fwd, edge_bwd;
  logic                   above_max;
  logic [OFFSET_BITS-1:0] off_abs;

  // Month length of the current month, or of the previous one when walking back
  assign leap      = gda_pkg::is_leap(yrem);
  assign len_month = (state == gda_pkg::ST_WALK && back) ? month - gda_pkg::month_t'(1)
                                                         : month;
  assign len       = gda_pkg::month_len(len_month, leap);
  assign left_p1   = len - day + gda_pkg::day_t'(1);

  // Shared subtractor: era reduction, then month steps
  always_comb begin
    opa = SubW'(mag);
    opb = SubW'(day);
    unique case (state)
      gda_pkg::ST_REDUCE: begin
        opa = SubW'(yrem);
        opb = SubW'(gda_pkg::ERA_YEARS);
      end
      gda_pkg::ST_WALK: begin
        opa = SubW'(mag);
        opb = back ? SubW'(day) : SubW'(left_p1);
      end
      default: begin
        opa = SubW'(mag);
        opb = SubW'(day);
      end
    endcase
  end

  assign diff    = opa - opb;
  assign sub_neg = diff[SubW-1];

  // Start date check and calendar edges
  assign start_bad = (year < gda_pkg::MIN_VALID_YEAR) || (month < gda_pkg::JANUARY) ||
                     (month > gda_pkg::DECEMBER) || (day == gda_pkg::day_t'(0)) ||
                     (day > len);
  assign edge_fwd  = (month == gda_pkg::DECEMBER) && (year >= gda_pkg::MAX_YEAR);
  assign edge_bwd  = (month == gda_pkg::JANUARY) && (year <= gda_pkg::MIN_YEAR);
  assign above_max = year > gda_pkg::MAX_YEAR;
  assign off_abs   = req.day_offset[OFFSET_BITS-1] ? (~req.day_offset + 1'b1)
                                                   : req.day_offset;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gda_pkg::ST_IDLE: begin
        if (req.valid) state_next = gda_pkg::ST_REDUCE;
      end
      gda_pkg::ST_REDUCE: begin
        if (sub_neg) state_next = gda_pkg::ST_CHECK;
      end
      gda_pkg::ST_CHECK: begin
        state_next = start_bad ? gda_pkg::ST_DONE : gda_pkg::ST_WALK;
      end
      gda_pkg::ST_WALK: begin
        if (mag == '0) begin
          state_next = gda_pkg::ST_DONE;
        end else if (!sub_neg && (back ? edge_bwd : edge_fwd)) begin
          state_next = gda_pkg::ST_DONE;
        end
      end
      gda_pkg::ST_DONE: begin
        if (rsp.ready) state_next = gda_pkg::ST_IDLE;
      end
      default: state_next = gda_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    year_next  = year;
    month_next = month;
    day_next   = day;
    yrem_next  = yrem;
    mag_next   = mag;
    back_next  = back;
    bad_next   = bad;
    ovf_next   = ovf;
    sy_next    = sy;
    sm_next    = sm;
    sd_next    = sd;
    unique case (state)
      gda_pkg::ST_IDLE: begin
        // capture the word
        year_next  = req.start_year;
        month_next = req.start_month;
        day_next   = req.start_day;
        yrem_next  = req.start_year;
        mag_next   = MagW'(off_abs);
        back_next  = req.day_offset[OFFSET_BITS-1];
        bad_next   = 1'b0;
        ovf_next   = 1'b0;
        sy_next    = req.start_year;
        sm_next    = req.start_month;
        sd_next    = req.start_day;
      end
      gda_pkg::ST_REDUCE: begin
        // strip whole eras off the year
        if (!sub_neg) yrem_next = gda_pkg::year_t'(diff);
      end
      gda_pkg::ST_CHECK: begin
        bad_next = start_bad;
      end
      gda_pkg::ST_WALK: begin
        if (mag == '0) begin
          ovf_next = above_max;
        end else if (!back) begin
          if (sub_neg) begin
            // land inside this month
            day_next = day + gda_pkg::day_t'(mag);
            mag_next = '0;
          end else if (edge_fwd) begin
            ovf_next = 1'b1;
          end else begin
            // advance to the first of the next month
            mag_next = MagW'(diff);
            day_next = gda_pkg::FIRST_DAY;
            if (month == gda_pkg::DECEMBER) begin
              month_next = gda_pkg::JANUARY;
              year_next  = year + gda_pkg::year_t'(1);
              yrem_next  = (yrem == gda_pkg::ERA_YEARS - gda_pkg::year_t'(1)) ? '0
                           : yrem + gda_pkg::year_t'(1);
            end else begin
              month_next = month + gda_pkg::month_t'(1);
            end
          end
        end else begin
          if (sub_neg) begin
            // land inside this month
            day_next = day - gda_pkg::day_t'(mag);
            mag_next = '0;
          end else if (edge_bwd) begin
            ovf_next = 1'b1;
          end else begin
            // step back to the last day of the previous month
            mag_next = MagW'(diff);
            if (month == gda_pkg::JANUARY) begin
              month_next = gda_pkg::DECEMBER;
              day_next   = gda_pkg::DECEMBER_LEN;
              year_next  = year - gda_pkg::year_t'(1);
              yrem_next  = (yrem == '0) ? gda_pkg::ERA_YEARS - gda_pkg::year_t'(1)
                           : yrem - gda_pkg::year_t'(1);
            end else begin
              month_next = month - gda_pkg::month_t'(1);
              day_next   = len;
            end
          end
        end
      end
      gda_pkg::ST_DONE: begin
        // hold the result
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gda_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    year  <= year_next;
    month <= month_next;
    day   <= day_next;
    yrem  <= yrem_next;
    mag   <= mag_next;
    back  <= back_next;
    bad   <= bad_next;
    ovf   <= ovf_next;
    sy    <= sy_next;
    sm    <= sm_next;
    sd    <= sd_next;
  end

  // Ports: a flagged word returns the start date
  assign req.ready         = (state == gda_pkg::ST_IDLE);
  assign rsp.valid         = (state == gda_pkg::ST_DONE);
  assign rsp.input_invalid = bad;
  assign rsp.year_overflow = ovf;
  assign rsp.result_year   = (bad || ovf) ? sy : year;
  assign rsp.result_month  = (bad || ovf) ? sm : month;
  assign rsp.result_day    = (bad || ovf) ? sd : day;

  `GDA_ASSERT_SAME(a_flags_exclusive, clk, rst, rsp.valid, !(bad && ovf))
  `GDA_ASSERT_SAME(a_result_in_range, clk, rst, rsp.valid && !bad && !ovf,
    (month >= gda_pkg::JANUARY) && (month <= gda_pkg::DECEMBER) &&
    (day != gda_pkg::day_t'(0)) && (year >= gda_pkg::MIN_YEAR) &&
    (year <= gda_pkg::MAX_YEAR))
  `GDA_ASSERT_SAME(a_walk_calendar, clk, rst, state == gda_pkg::ST_WALK,
    (yrem < gda_pkg::ERA_YEARS) && (day != gda_pkg::day_t'(0)) &&
    (day <= gda_pkg::month_len(month, leap)))
  `GDA_ASSERT_NEXT(a_accept_busy, clk, rst, req.valid && req.ready,
    !req.ready && !rsp.valid)

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date adder testbench
// Sends start dates with signed day offsets through the request channel,
// predicts each shifted date from a day-serial calendar model and checks
// every response word field by field, under random and long stalls.
// ----------------------------------------------------------------------------

module testbench;

  localparam int OFFSET_BITS = gda_pkg::OFFSET_BITS_DEF;
  localparam int NUM_RANDOM  = 77;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 200000;
  localparam int DAYS_PER_CYCLE = 146097;

  typedef logic signed [OFFSET_BITS-1:0] offset_t;

  typedef struct {
    gda_pkg::year_t  y;
    gda_pkg::month_t m;
    gda_pkg::day_t   d;
    offset_t         offset;
    bit              drain;
  } date_word_t;

  typedef struct {
    gda_pkg::year_t  y;
    gda_pkg::month_t m;
    gda_pkg::day_t   d;
    logic            bad;
    logic            ovf;
  } shifted_date_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gda_in_if #(.OFFSET_BITS(OFFSET_BITS)) req_if ();
  gda_out_if rsp_if ();

  gregorian_date_add_days_top #(.OFFSET_BITS(OFFSET_BITS)) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  date_word_t    pending_dates[$];
  shifted_date_t shifted_dates[$];

  int total_words;
  int words_sent     = 0;
  int words_received = 0;
  int error_count    = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  int stall_cycles   = 0;

  always #4 clk = ~clk;

  // Days in a month under the Gregorian leap rule; zero for bad month codes
  function automatic int days_in_month(int y, int m);
    int lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    bit leap;
    if (m < int'(gda_pkg::JANUARY) || m > int'(gda_pkg::DECEMBER)) begin
      return 0;
    end
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    return (m == int'(gda_pkg::FEBRUARY) && leap) ? lens[m] + 1 : lens[m];
  endfunction

  // Day serial counted from March 1 of year zero; years start in March
  function automatic longint civil_to_serial(longint y, longint m, longint d);
    longint yr, cyc, yr_in_cyc, mar_month, day_in_yr, day_in_cyc;
    yr         = (m <= longint'(gda_pkg::FEBRUARY)) ? y - 1 : y;
    cyc        = yr / 400;
    yr_in_cyc  = yr - cyc * 400;
    mar_month  = (m > longint'(gda_pkg::FEBRUARY)) ? m - 3 : m + 9;
    day_in_yr  = (153 * mar_month + 2) / 5 + d - 1;
    day_in_cyc = yr_in_cyc * 365 + yr_in_cyc / 4 - yr_in_cyc / 100 + day_in_yr;
    return cyc * DAYS_PER_CYCLE + day_in_cyc;
  endfunction

  // Invert the day serial for non-negative counts
  function automatic void serial_to_civil(input longint s, output gda_pkg::year_t y,
                                          output gda_pkg::month_t m,
                                          output gda_pkg::day_t d);
    longint cyc, day_in_cyc, yr_in_cyc, yr, day_in_yr, mar_month, mon;
    cyc        = s / DAYS_PER_CYCLE;
    day_in_cyc = s - cyc * DAYS_PER_CYCLE;
    yr_in_cyc  = (day_in_cyc - day_in_cyc / 1460 + day_in_cyc / 36524
                  - day_in_cyc / 146096) / 365;
    yr         = yr_in_cyc + cyc * 400;
    day_in_yr  = day_in_cyc - (365 * yr_in_cyc + yr_in_cyc / 4 - yr_in_cyc / 100);
    mar_month  = (5 * day_in_yr + 2) / 153;
    d          = gda_pkg::day_t'(day_in_yr - (153 * mar_month + 2) / 5 + 1);
    mon        = (mar_month < 10) ? mar_month + 3 : mar_month - 9;
    if (mon <= longint'(gda_pkg::FEBRUARY)) begin
      yr = yr + 1;
    end
    y = gda_pkg::year_t'(yr);
    m = gda_pkg::month_t'(mon);
  endfunction

  // Predict the shifted date and status flags for one request word
  function automatic shifted_date_t shift_date(date_word_t w);
    shifted_date_t r;
    longint s;
    r.y   = w.y;
    r.m   = w.m;
    r.d   = w.d;
    r.bad = 1'b0;
    r.ovf = 1'b0;
    if (w.y < gda_pkg::MIN_VALID_YEAR || w.m < gda_pkg::JANUARY ||
        w.m > gda_pkg::DECEMBER || w.d < gda_pkg::FIRST_DAY ||
        int'(w.d) > days_in_month(int'(w.y), int'(w.m))) begin
      r.bad = 1'b1;
    end else begin
      s = civil_to_serial(w.y, w.m, w.d) + longint'(w.offset);
      if (s < civil_to_serial(gda_pkg::MIN_YEAR, gda_pkg::JANUARY, gda_pkg::FIRST_DAY) ||
          s > civil_to_serial(gda_pkg::MAX_YEAR, gda_pkg::DECEMBER,
                              gda_pkg::DECEMBER_LEN)) begin
        r.ovf = 1'b1;
      end else begin
        serial_to_civil(s, r.y, r.m, r.d);
      end
    end
    return r;
  endfunction

  task automatic queue_date(int y, int m, int d, longint off, bit drain = 1'b0);
    date_word_t w;
    w.y      = gda_pkg::year_t'(y);
    w.m      = gda_pkg::month_t'(m);
    w.d      = gda_pkg::day_t'(d);
    w.offset = offset_t'(off);
    w.drain  = drain;
    pending_dates.push_back(w);
  endtask

  // Mostly well-formed dates with short hops; some long hops and raw noise
  task automatic queue_random_date(bit drain);
    int y, m, d, pick;
    longint off;
    pick = $urandom_range(99);
    if (pick < 85) begin
      y = ($urandom_range(3) == 0) ? $urandom_range(1900, 9999) : $urandom_range(1900, 2600);
      m = $urandom_range(int'(gda_pkg::JANUARY), int'(gda_pkg::DECEMBER));
      d = $urandom_range(1, days_in_month(y, m));
    end else begin
      y = $urandom_range(0, 16383);
      m = $urandom_range(0, 15);
      d = $urandom_range(0, 31);
    end
    if ($urandom_range(19) == 0) begin
      off = longint'(offset_t'($urandom()));
    end else begin
      off = longint'($urandom_range(0, 4000)) - 2000;
    end
    queue_date(y, m, d, off, drain);
  endtask

  // Sender: first 27% idle, then 68%, then none
  function automatic int sender_idle_pct(int sent);
    int ph;
    ph = sent * 3 / total_words;
    return (ph == 0) ? 27 : (ph == 1) ? 68 : 0;
  endfunction

  // Receiver: first 68% idle, then 27%, then none
  function automatic int receiver_idle_pct(int got);
    int ph;
    ph = got * 3 / total_words;
    return (ph == 0) ? 68 : (ph == 1) ? 27 : 0;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Drive request words from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        date_word_t w;
        w.y      = req_if.start_year;
        w.m      = req_if.start_month;
        w.d      = req_if.start_day;
        w.offset = req_if.day_offset;
        w.drain  = 1'b0;
        shifted_dates.push_back(shift_date(w));
        words_sent++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_dates.size() != 0 &&
            !(pending_dates[0].drain && shifted_dates.size() != 0) &&
            $urandom_range(99) >= sender_idle_pct(words_sent)) begin
          req_if.valid       <= 1'b1;
          req_if.start_year  <= pending_dates[0].y;
          req_if.start_month <= pending_dates[0].m;
          req_if.start_day   <= pending_dates[0].d;
          req_if.day_offset  <= pending_dates[0].offset;
          void'(pending_dates.pop_front());
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Accept and check response words; hold off once for a long stretch
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (shifted_dates.size() == 0) begin
          $error("response word with no request outstanding");
          error_count++;
        end else begin
          shifted_date_t e;
          e = shifted_dates.pop_front();
          compare_field("result_year", e.y, rsp_if.result_year);
          compare_field("result_month", e.m, rsp_if.result_month);
          compare_field("result_day", e.d, rsp_if.result_day);
          compare_field("input_invalid", e.bad, rsp_if.input_invalid);
          compare_field("year_overflow", e.ovf, rsp_if.year_overflow);
        end
        words_received++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!hold_done && words_received >= total_words * 2 / 3) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct(words_received));
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    longint to_first_year;

    to_first_year = civil_to_serial(1, 1, 1) - civil_to_serial(1900, 1, 1);

    // Directed words: field extremes, bad dates, leap rules, range edges
    queue_date(2024, 3, 15, 0);
    queue_date(0, 0, 0, 0);
    queue_date(1899, 12, 31, 1);
    queue_date(1900, 1, 1, 0);
    queue_date(2000, 0, 10, 5);
    queue_date(2000, 13, 1, 5);
    queue_date(2000, 15, 31, -5);
    queue_date(2000, 5, 0, 1);
    queue_date(2001, 4, 31, 1);
    queue_date(1900, 2, 29, 1);
    queue_date(2100, 2, 29, 1);
    queue_date(2000, 2, 29, 365);
    queue_date(2004, 2, 28, 1);
    queue_date(1999, 12, 31, 1);
    queue_date(2000, 3, 1, -1);
    queue_date(1900, 1, 1, 1048575);
    queue_date(1900, 1, 1, -1048576);
    queue_date(1900, 1, 1, to_first_year);
    queue_date(1900, 1, 1, to_first_year - 1);
    queue_date(9999, 12, 30, 1);
    queue_date(9999, 12, 31, 1);
    queue_date(16383, 12, 31, 0);
    queue_date(10000, 1, 1, -1048576);

    // Random words; pause the sender twice until the block drains
    for (int i = 0; i < NUM_RANDOM; i++) begin
      queue_random_date(i == 0 || i == NUM_RANDOM / 2);
    end
    total_words = pending_dates.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (pending_dates.size() == 0 && !req_if.valid);
    wait (shifted_dates.size() == 0);
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
